### src/positional_array_list_engine_defines.svh
// Assertion macros for the checker file of the list engine.
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PALE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PALE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pale_pkg.sv
// Types and codes shared by the list engine modules.
package pale_pkg;

  // Request modes.
  localparam logic [2:0] MODE_GET    = 3'd0;
  localparam logic [2:0] MODE_LOCATE = 3'd1;
  localparam logic [2:0] MODE_INSERT = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_POS   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_LOC,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_FIRST,
    S_DEL_SHIFT,
    S_RESP
  } state_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [7:0]  found_position;
    logic [7:0]  count;
    logic        is_empty;
  } res_t;

endpackage

### src/pale_ram.sv
// Entry store: one write port and one registered read port.
module pale_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data
);

  logic [31:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/pale_ctrl.sv
// Request sequencer: decodes an item and walks the entry store to serve it.
module pale_ctrl #(
  parameter int CAPACITY = 128,
  parameter int AW       = 7,
  parameter int CW       = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [2:0]     in_mode,
  input  logic [7:0]     in_pos,
  input  logic [31:0]    in_value,
  output logic           rd_en,
  output logic [AW-1:0]  rd_addr,
  input  logic [31:0]    rd_data,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output logic [31:0]   wr_data,
  output logic           res_valid,
  input  logic           res_ready,
  output pale_pkg::res_t res
);

  import pale_pkg::*;

  // Wide enough for a position, the count and the count plus one.
  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [31:0]   read_r, read_nxt;
  logic [7:0]    found_r, found_nxt;

  logic [PW-1:0] pos_w, cnt_w, pos_m1, idx_p1_w;
  logic [CW-1:0] cnt_m1, idx_p1;
  logic          pos_ok_get, pos_ok_ins, full, idx_last, need_shift;

  // Range checks and index arithmetic.
  assign pos_w      = PW'(in_pos);
  assign cnt_w      = PW'(cnt_r);
  assign pos_m1     = pos_w - PW'(1);
  assign cnt_m1     = cnt_r - CW'(1);
  assign idx_p1     = CW'(idx_r) + CW'(1);
  assign idx_p1_w   = PW'(idx_p1);
  assign pos_ok_get = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
  assign need_shift = pos_w <= cnt_w;
  assign full       = cnt_r == CW'(CAPACITY);
  assign idx_last   = idx_p1 == cnt_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_GET:    state_nxt = pos_ok_get ? S_GET : S_RESP;
            MODE_LOCATE: state_nxt = (cnt_r != '0) ? S_LOC : S_RESP;
            MODE_INSERT: begin
              if (!pos_ok_ins || full) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = need_shift ? S_INS_SHIFT : S_INS_PUT;
              end
            end
            MODE_DELETE: begin
              state_nxt = ((cnt_r != '0) && pos_ok_get) ? S_DEL_FIRST : S_RESP;
            end
            default:     state_nxt = S_RESP;
          endcase
        end
      end
      S_GET:       state_nxt = S_RESP;
      S_LOC: begin
        if ((rd_data == val_r) || idx_last) begin
          state_nxt = S_RESP;
        end
      end
      S_INS_SHIFT: begin
        if (idx_r == tgt_r) begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT:   state_nxt = S_RESP;
      S_DEL_FIRST: state_nxt = idx_last ? S_RESP : S_DEL_SHIFT;
      S_DEL_SHIFT: begin
        if (idx_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Memory accesses and datapath updates. A read and a write in the same
  // cycle always go to different entries, so no forwarding is needed.
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_data;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    tgt_nxt    = tgt_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    read_nxt   = read_r;
    found_nxt  = found_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt    = in_value;
          tgt_nxt    = pos_m1[AW-1:0];
          status_nxt = ST_OK;
          read_nxt   = '0;
          found_nxt  = '0;
          unique case (in_mode)
            MODE_GET: begin
              if (pos_ok_get) begin
                rd_en   = 1'b1;
                rd_addr = pos_m1[AW-1:0];
              end else begin
                status_nxt = ST_BAD_POS;
              end
            end
            MODE_LOCATE: begin
              if (cnt_r != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                idx_nxt = '0;
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            MODE_INSERT: begin
              if (!pos_ok_ins) begin
                status_nxt = ST_BAD_POS;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else if (need_shift) begin
                // Start from the top entry and move downwards.
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
                idx_nxt = cnt_m1[AW-1:0];
              end
            end
            MODE_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (!pos_ok_get) begin
                status_nxt = ST_BAD_POS;
              end else begin
                rd_en   = 1'b1;
                rd_addr = pos_m1[AW-1:0];
                idx_nxt = pos_m1[AW-1:0];
              end
            end
            MODE_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      S_GET: read_nxt = rd_data;
      S_LOC: begin
        // Compare the entry that has just been read, fetch the next one.
        if (rd_data == val_r) begin
          found_nxt = idx_p1_w[7:0];
        end else if (idx_last) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_p1[AW-1:0];
          idx_nxt = idx_p1[AW-1:0];
        end
      end
      S_INS_SHIFT: begin
        // Move the entry just read one place up.
        wr_en   = 1'b1;
        wr_addr = idx_p1[AW-1:0];
        if (idx_r != tgt_r) begin
          rd_en   = 1'b1;
          rd_addr = idx_r - AW'(1);
          idx_nxt = idx_r - AW'(1);
        end
      end
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = tgt_r;
        wr_data = val_r;
        cnt_nxt = cnt_r + CW'(1);
      end
      S_DEL_FIRST, S_DEL_SHIFT: begin
        if (state_r == S_DEL_FIRST) begin
          read_nxt = rd_data;
        end else begin
          // Move the entry just read one place down.
          wr_en   = 1'b1;
          wr_addr = idx_r - AW'(1);
        end
        if (idx_last) begin
          cnt_nxt = cnt_m1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_p1[AW-1:0];
          idx_nxt = idx_p1[AW-1:0];
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    tgt_r    <= tgt_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    read_r   <= read_nxt;
    found_r  <= found_nxt;
  end

  // Handshakes and the finished result.
  assign in_ready           = state_r == S_IDLE;
  assign res_valid          = state_r == S_RESP;
  assign res.status         = status_r;
  assign res.read_value     = read_r;
  assign res.found_position = found_r;
  assign res.count          = cnt_w[7:0];
  assign res.is_empty       = cnt_r == '0;

endmodule

### src/pale_out.sv
// Output register that holds a result item until the sink takes it.
module pale_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  output logic           res_ready,
  input  pale_pkg::res_t res,
  output logic           out_valid,
  input  logic           out_ready,
  output pale_pkg::res_t out_data
);

  import pale_pkg::*;

  logic valid_r;
  res_t data_r;

  // The register is free when empty or being emptied this cycle.
  assign res_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### src/positional_array_list_engine.sv
// Top level of the positional list engine.
//
//   Channel  Direction  Payload
//   in_      slave      tuser: mode; tdata: position, value
//   out_     master     tuser: status; tdata: read_value, found_position, count, is_empty
//
// Items are served through the single read and single write port of the store: clear or a
// rejected request goes straight to the result, get reads one entry, locate compares
// entries in turn up to a match or the last, insert and delete shift the later entries.
// Reset clears the count at once; the store itself is not cleared.
// A new item is taken once the previous result has entered the output register,
// which holds it while out_tready is low.
module positional_array_list_engine #(
  parameter int CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] mode
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic [55:0] out_tdata   // [31:0] read_value, [39:32] found_position,
                                  // [47:40] count, [48] is_empty, rest zero
);

  import pale_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   rd_data, wr_data;
  logic          res_valid, res_ready;
  res_t          res, out_res;

  // Entry store.
  pale_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // Request sequencer.
  pale_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_tuser),
    .in_pos   (in_tdata[7:0]),
    .in_value (in_tdata[39:8]),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Result register.
  pale_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_res)
  );

  // Pack the result item onto the stream.
  assign out_tuser = out_res.status;
  assign out_tdata = {7'b0, out_res.is_empty, out_res.count,
                      out_res.found_position, out_res.read_value};

endmodule

### src/pale_checker.sv
// Port-level checks for the list engine and their binding to the top level.
`include "positional_array_list_engine_defines.svh"

module pale_checker #(
  parameter int CAPACITY = 128
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [2:0]  out_tuser,
  input logic [55:0] out_tdata
);

  import pale_pkg::*;

  // The engine is not ready in the cycle after it takes an item.
  `PALE_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted back to back")

  // A result waiting for the sink is held unchanged.
  `PALE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // Only defined status codes are reported.
  `PALE_ASSERT_SAME(a_status_code, out_tvalid, out_tuser <= ST_NOT_FOUND, "undefined status code")

  // A found position is only given with a successful status.
  `PALE_ASSERT_SAME(a_found_ok, out_tvalid && (out_tdata[39:32] != 8'd0), out_tuser == ST_OK, "position found without ok status")

  // The empty flag follows the count while the count fits the field.
  `PALE_ASSERT_SAME(a_empty_count, out_tvalid && (CAPACITY < 256), out_tdata[48] == (out_tdata[47:40] == 8'd0), "empty flag disagrees with count")

endmodule

bind positional_array_list_engine pale_checker #(.CAPACITY(CAPACITY)) u_pale_checker (.*);

### tb/positional_array_list_engine_tb.sv
// Self-checking testbench for the positional list engine with random stimulus and stalls.
`timescale 1ns / 100ps

module positional_array_list_engine_tb;
  import pale_pkg::*;

  localparam int LIST_DEPTH      = 128;
  localparam int RANDOM_ITEMS    = 1350;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTS     = 40;

  // Modes that the block answers without doing anything.
  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  pos;
    logic [31:0] value;
  } list_req_t;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_NOISY} req_mix_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser   = '0;   // [2:0] mode
  logic [39:0] in_tdata   = '0;   // [7:0] position, [39:8] value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  out_tuser;         // [2:0] status
  logic [55:0] out_tdata;         // [31:0] read_value, [39:32] found_position,
                                  // [47:40] count, [48] is_empty

  positional_array_list_engine #(.CAPACITY(LIST_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Reset is released on a falling edge.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Shadow copy of the list, updated as each item is accepted.
  logic [31:0] list_words [LIST_DEPTH];
  int          list_len = 0;

  list_req_t   request_backlog [$];
  res_t        awaited_results [$];
  logic [31:0] value_pool [16];

  int gen_len        = 0;
  int reqs_total     = 0;
  int reqs_accepted  = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int mode_tally   [8];
  int status_tally [8];

  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;

  int send_gap      = 0;
  bit send_quiet    = 1'b0;
  int take_stall    = 0;
  bit take_quiet    = 1'b0;
  int results_taken = 0;
  int idle_cycles   = 0;

  // Works out the result of one request and applies it to the shadow list.
  function automatic res_t apply_list_request(logic [2:0] mode, logic [7:0] pos,
                                              logic [31:0] value);
    res_t r;
    int   p;
    int   k;
    r = '0;
    r.status = ST_OK;
    p = int'(pos);
    case (mode)
      MODE_GET: begin
        if (p < 1 || p > list_len) r.status = ST_BAD_POS;
        else r.read_value = list_words[p - 1];
      end
      MODE_LOCATE: begin
        r.status = ST_NOT_FOUND;
        for (k = 0; k < list_len; k++) begin
          if (list_words[k] == value) begin
            r.found_position = 8'(k + 1);
            r.status = ST_OK;
            break;
          end
        end
      end
      MODE_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = ST_BAD_POS;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (k = list_len; k >= p; k--) list_words[k] = list_words[k - 1];
          list_words[p - 1] = value;
          list_len++;
        end
      end
      MODE_DELETE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          r.read_value = list_words[p - 1];
          for (k = p; k < list_len; k++) list_words[k - 1] = list_words[k];
          list_len--;
        end
      end
      MODE_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count    = 8'(list_len);
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  // Queues one item and follows the list length it will leave behind.
  function automatic void queue_request(logic [2:0] mode, logic [7:0] pos,
                                        logic [31:0] value);
    list_req_t r;
    r.mode  = mode;
    r.pos   = pos;
    r.value = value;
    request_backlog.push_back(r);
    reqs_total++;
    case (mode)
      MODE_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_DEPTH) gen_len++;
      MODE_DELETE: if (gen_len > 0 && pos >= 1 && pos <= gen_len) gen_len--;
      MODE_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endfunction

  // Draws one random item of the given mix; returns 1 unless the mode is a spare one.
  function automatic int queue_random(req_mix_t mix);
    int          w;
    logic [2:0]  mode;
    logic [7:0]  pos;
    logic [31:0] value;
    w = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:
        mode = (w < 70) ? MODE_INSERT : (w < 78) ? MODE_DELETE :
               (w < 88) ? MODE_GET : (w < 98) ? MODE_LOCATE : 3'($urandom_range(5, 7));
      MIX_SHRINK:
        mode = (w < 65) ? MODE_DELETE : (w < 72) ? MODE_INSERT :
               (w < 84) ? MODE_GET : (w < 96) ? MODE_LOCATE : 3'($urandom_range(5, 7));
      MIX_BALANCED:
        mode = (w < 30) ? MODE_INSERT : (w < 55) ? MODE_DELETE :
               (w < 75) ? MODE_GET : (w < 95) ? MODE_LOCATE :
               (w < 97) ? MODE_CLEAR : 3'($urandom_range(5, 7));
      default: mode = 3'($urandom_range(0, 7));
    endcase

    // Mostly legal positions, with a share drawn over the whole field.
    if (mix == MIX_NOISY || $urandom_range(0, 9) == 0)
      pos = 8'($urandom_range(0, 255));
    else if (mode == MODE_INSERT)
      pos = 8'($urandom_range(1, gen_len + 1));
    else if (gen_len == 0)
      pos = 8'($urandom_range(0, 2));
    else
      pos = 8'($urandom_range(1, gen_len));

    // A small pool of words makes locate hit often and repeat entries.
    if (mix == MIX_NOISY || $urandom_range(0, 2) == 0) value = $urandom;
    else value = value_pool[$urandom_range(0, 15)];

    queue_request(mode, pos, value);
    return (mode <= MODE_CLEAR) ? 1 : 0;
  endfunction

  // Prints one line per mismatch, up to a limit, and counts them all.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
    mismatches++;
  endtask

  // Stimulus: a directed opening, then phases that fill, empty and churn the list.
  initial begin : build_stimulus
    int       issued;
    int       phase;
    int       extra;
    int       span;
    req_mix_t mix;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 16; i++) value_pool[i] = $urandom;

    // Empty list: get and insert at bad positions, locate misses, delete reports empty first.
    queue_request(MODE_GET,    8'd1,   32'd0);
    queue_request(MODE_GET,    8'd0,   32'd0);
    queue_request(MODE_LOCATE, 8'd0,   32'd0);
    queue_request(MODE_DELETE, 8'd1,   32'd0);
    queue_request(MODE_DELETE, 8'd0,   32'd0);
    queue_request(MODE_INSERT, 8'd0,   32'd5);
    queue_request(MODE_INSERT, 8'd2,   32'd5);
    // Build a short list from the extreme words.
    queue_request(MODE_INSERT, 8'd1,   32'h8000_0000);
    queue_request(MODE_INSERT, 8'd2,   32'h7fff_ffff);
    queue_request(MODE_INSERT, 8'd1,   32'hffff_ffff);
    queue_request(MODE_INSERT, 8'd255, 32'd1);
    queue_request(MODE_GET,    8'd3,   32'd0);
    queue_request(MODE_GET,    8'd4,   32'd0);
    queue_request(MODE_GET,    8'd255, 32'hffff_ffff);
    queue_request(MODE_LOCATE, 8'd0,   32'h7fff_ffff);
    // A duplicate word: locate must return the first position.
    queue_request(MODE_INSERT, 8'd4,   32'h8000_0000);
    queue_request(MODE_LOCATE, 8'd255, 32'h8000_0000);
    queue_request(MODE_LOCATE, 8'd0,   32'h0000_0000);
    queue_request(MODE_DELETE, 8'd0,   32'd0);
    queue_request(MODE_DELETE, 8'd5,   32'd0);
    queue_request(MODE_DELETE, 8'd2,   32'd0);
    queue_request(MODE_SPARE_5, 8'd1,  32'hffff_ffff);
    queue_request(MODE_SPARE_6, 8'd255, 32'd0);
    queue_request(MODE_SPARE_7, 8'd0,  32'h1234_5678);
    queue_request(MODE_CLEAR,  8'd0,   32'd0);
    queue_request(MODE_GET,    8'd1,   32'd0);

    issued = 0;
    phase  = 0;
    while (issued < RANDOM_ITEMS) begin
      mix = req_mix_t'(phase % 4);
      extra = 0;
      span  = 0;
      case (mix)
        // Fill to capacity, then keep pushing against the full list.
        MIX_GROW:
          while (extra < 6 && span < 400 && issued < RANDOM_ITEMS) begin
            if (gen_len == LIST_DEPTH) extra++;
            issued += queue_random(mix);
            span++;
          end
        // Drain to empty, then keep deleting from the empty list.
        MIX_SHRINK:
          while (extra < 4 && span < 400 && issued < RANDOM_ITEMS) begin
            if (gen_len == 0) extra++;
            issued += queue_random(mix);
            span++;
          end
        default:
          for (int i = 0; i < ((mix == MIX_BALANCED) ? 80 : 60) && issued < RANDOM_ITEMS; i++)
            issued += queue_random(mix);
      endcase
      phase++;
    end

    // Wait for every item and result, then let the block settle.
    while (reqs_accepted < reqs_total || awaited_results.size() != 0) @(negedge clk);
    repeat (LIST_DEPTH + 8) @(negedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0d results never arrived", awaited_results.size());
      mismatches++;
    end

    $display("Sent %0d items: get %0d, locate %0d, insert %0d, delete %0d, clear %0d, spare %0d.",
             reqs_accepted, mode_tally[0], mode_tally[1], mode_tally[2], mode_tally[3],
             mode_tally[4], mode_tally[5] + mode_tally[6] + mode_tally[7]);
    $display("Checked %0d results: ok %0d, bad position %0d, full %0d, empty %0d, missed %0d.",
             results_seen, status_tally[0], status_tally[1], status_tally[2],
             status_tally[3], status_tally[4]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Sender: presents queued items on the falling edge with random gaps.
  always @(negedge clk) begin : drive_requests
    list_req_t req_out;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!in_tvalid || in_fire) begin
      if (in_tvalid) begin
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        send_gap = send_quiet ? 0 : $urandom_range(0, 16);
      end
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap--;
      end else if (request_backlog.size() != 0) begin
        req_out = request_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= req_out.mode;
        in_tdata  <= {req_out.value, req_out.pos};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls per result, and now and then a long hold-off.
  always @(negedge clk) begin : take_results
    if (!rst_n) begin
      out_tready <= 1'b0;
      take_stall = 0;
    end else begin
      if (out_fire) begin
        results_taken++;
        if ($urandom_range(0, 39) == 0) take_quiet = !take_quiet;
        take_stall = take_quiet ? 0 : $urandom_range(0, 16);
        if (results_taken % 500 == 250) take_stall = HOLD_OFF_CYCLES;
      end
      if (take_stall > 0) begin
        out_tready <= 1'b0;
        take_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: checks each result against the oldest expectation and predicts new items.
  always @(posedge clk) begin : watch_channels
    res_t want;
    if (!rst_n) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_tvalid && in_tready;
      out_fire <= out_tvalid && out_tready;
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no item awaiting it", out_tdata[31:0], 32'd0);
        end else begin
          want = awaited_results.pop_front();
          status_tally[want.status]++;
          if (out_tuser !== want.status)
            report_mismatch("status", 32'(out_tuser), 32'(want.status));
          if (out_tdata[31:0] !== want.read_value)
            report_mismatch("read_value", out_tdata[31:0], want.read_value);
          if (out_tdata[39:32] !== want.found_position)
            report_mismatch("found_position", 32'(out_tdata[39:32]), 32'(want.found_position));
          if (out_tdata[47:40] !== want.count)
            report_mismatch("count", 32'(out_tdata[47:40]), 32'(want.count));
          if (out_tdata[48] !== want.is_empty)
            report_mismatch("is_empty", 32'(out_tdata[48]), 32'(want.is_empty));
          if (out_tdata[55:49] !== '0)
            report_mismatch("padding", 32'(out_tdata[55:49]), 32'd0);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(apply_list_request(in_tuser, in_tdata[7:0], in_tdata[39:8]));
        mode_tally[in_tuser]++;
        reqs_accepted++;
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("No item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
